/* sv/tom_pkg.sv */
`timescale 1ns / 1ps
// Package for the tone oscillator mixer: sizes, beat types, register indexes,
// the waveform shape decode and the quarter-wave sine table. Depends on nothing.
package tom_pkg;

  localparam int PHASE_BITS = 32;
  localparam int SINE_DEPTH = 1024;
  localparam int COUNT_BITS = 24;

  localparam int SIN_AW = $clog2(SINE_DEPTH);
  localparam int QAW    = SIN_AW - 1;
  localparam int QTR    = SINE_DEPTH / 4;

  localparam int STEP_W   = 32;
  localparam int GAIN_W   = 16;
  localparam int INST_W   = 7;
  localparam int NLEN_W   = 24;
  localparam int LEN_W    = (COUNT_BITS > NLEN_W) ? COUNT_BITS : NLEN_W;
  localparam int SAMPLE_W = 16;
  localparam int WAVE_W   = 17;
  localparam int MAG_W    = 16;
  localparam int SCL_W    = 31;
  localparam int PROD_W   = SCL_W + GAIN_W;
  localparam int TMAG_W   = PROD_W - 29;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_GAIN        = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_INSTRUMENT  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_NOTE_LENGTH = CFG_IDX_W'(3);

  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(16384);
  localparam logic [INST_W-1:0] INST_RESET = INST_W'(1);

  localparam logic signed [WAVE_W-1:0]   WAVE_FULL  = 17'sd32768;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

  typedef enum logic [1:0] {
    SHAPE_SINE,
    SHAPE_SQUARE,
    SHAPE_SAW,
    SHAPE_TRI
  } shape_t;

  typedef struct packed {
    logic                       restart;
    logic signed [SAMPLE_W-1:0] mix_in;
  } in_beat_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       clipped;
    logic                       note_active;
  } out_beat_t;

  typedef struct packed {
    logic                       active;
    logic signed [WAVE_W-1:0]   wave;
    logic signed [SAMPLE_W-1:0] mix;
  } tone_stage_t;

  typedef logic [MAG_W-1:0] qtab_t [0:QTR];

  function automatic shape_t shape_of(input logic [INST_W-1:0] inst);
    shape_t s;
    case (inst) inside
      7'd3, 7'd6, 7'd29, 7'd37, 7'd38, 7'd40: s = SHAPE_SQUARE;
      7'd28, 7'd33, 7'd39:                    s = SHAPE_SAW;
      7'd95, 7'd96, 7'd100:                   s = SHAPE_TRI;
      default:                                s = SHAPE_SINE;
    endcase
    return s;
  endfunction

  localparam longint unsigned Q30_ONE    = 64'd1 << 30;
  localparam longint unsigned Q31_ONE    = 64'd1 << 31;
  localparam longint unsigned TWO_PI_Q29 = 64'd3373259426;
  localparam longint unsigned TAYLOR_DIV [0:4] = '{64'd110, 64'd72, 64'd42, 64'd20, 64'd6};

  // Sine of the first quarter, Q30 Taylor series to x^11, rounded to Q15.
  function automatic logic [MAG_W-1:0] sine_q_entry(input int k);
    longint unsigned fq;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned s;
    longint unsigned v;
    fq = (unsigned'(longint'(k)) << 32) / SINE_DEPTH;
    if (fq > Q30_ONE) fq = Q31_ONE - fq;
    x  = (fq * TWO_PI_Q29) >> 31;
    x2 = (x * x) >> 30;
    t  = Q30_ONE;
    for (int i = 0; i < 5; i++) begin
      t = Q30_ONE - ((x2 * t) >> 30) / TAYLOR_DIV[i];
    end
    s = (x * t) >> 30;
    v = (s * 64'd32768 + (64'd1 << 29)) >> 30;
    return v[MAG_W-1:0];
  endfunction

  function automatic qtab_t build_qtab();
    qtab_t q;
    for (int k = 0; k <= QTR; k++) begin
      q[k] = sine_q_entry(k);
    end
    return q;
  endfunction

  localparam qtab_t SIN_QTAB = build_qtab();

endpackage

/* sv/tone_oscillator_mixer.sv */
`timescale 1ns / 1ps
// Top level of the tone oscillator mixer: configuration registers, phase and
// sample counters, and a two-stage pipeline. Depends on tom_pkg, tom_shape and tom_scale.
//
//   channel  direction  handshake              payload
//   in_      input      in_valid / in_stall    in_beat_t: restart, mix_in
//   out_     output     out_valid / out_stall  out_beat_t: sample_out, clipped, note_active
//   cfg_     input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One beat is accepted per cycle while in_stall is low; results pass s1_r, then out_r.
// The first stage holds the shape value, the second the scaled and mixed sample.
// A stalled output holds both stages; the input stalls only when the first stage is full.
// Synchronous active-low reset clears the counters, valid flags and registers to defaults.
// The configuration port is always ready.
module tone_oscillator_mixer (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  tom_pkg::in_beat_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output tom_pkg::out_beat_t             out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tom_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tom_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tom_pkg::*;

  logic [PHASE_BITS-1:0] step_ext;
  logic [GAIN_W-1:0]     gain_r;
  logic [STEP_W-1:0]     step_r;
  logic [INST_W-1:0]     inst_r;
  logic [NLEN_W-1:0]     nlen_r;
  logic [PHASE_BITS-1:0] phase_r;
  logic [PHASE_BITS-1:0] phase_nxt;
  logic [COUNT_BITS-1:0] count_r;
  logic [COUNT_BITS-1:0] count_nxt;

  logic [PHASE_BITS+STEP_W-1:0] step_wide;
  logic [PHASE_BITS-1:0]        phase_use;
  logic [COUNT_BITS-1:0]        count_use;
  logic [LEN_W-1:0]             len;
  logic                         active;
  logic signed [WAVE_W-1:0]     wave;

  logic        in_acc;
  logic        s2_load;
  logic        s1_valid_r;
  tone_stage_t s1_r;
  tone_stage_t s1_nxt;
  out_beat_t   result;
  out_beat_t   out_r;

  assign step_wide = {{PHASE_BITS{1'b0}}, step_r};
  assign step_ext  = step_wide[PHASE_BITS-1:0];

  assign phase_use = in_data.restart ? '0 : phase_r;
  assign count_use = in_data.restart ? '0 : count_r;

  assign len = (LEN_W'(nlen_r) > LEN_W'({COUNT_BITS{1'b1}})) ?
               LEN_W'({COUNT_BITS{1'b1}}) : LEN_W'(nlen_r);
  assign active = LEN_W'(count_use) < len;

  tom_shape u_shape (
    .phase      (phase_use),
    .instrument (inst_r),
    .wave       (wave)
  );

  assign s1_nxt.active = active;
  assign s1_nxt.wave   = wave;
  assign s1_nxt.mix    = in_data.mix_in;

  assign phase_nxt = active ? phase_use + step_ext : phase_use;
  assign count_nxt = active ? count_use + COUNT_BITS'(1) : count_use;

  assign s2_load   = !out_valid || !out_stall;
  assign in_stall  = s1_valid_r && !s2_load;
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  tom_scale u_scale (
    .stage  (s1_r),
    .gain   (gain_r),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r     <= '0;
      gain_r     <= GAIN_RESET;
      inst_r     <= INST_RESET;
      nlen_r     <= '0;
      phase_r    <= '0;
      count_r    <= '0;
      s1_valid_r <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PHASE_STEP:  step_r <= cfg_data[STEP_W-1:0];
          REG_GAIN:        gain_r <= cfg_data[GAIN_W-1:0];
          REG_INSTRUMENT:  inst_r <= cfg_data[INST_W-1:0];
          REG_NOTE_LENGTH: nlen_r <= cfg_data[NLEN_W-1:0];
          default: ;
        endcase
      end
      if (in_acc) begin
        phase_r <= phase_nxt;
        count_r <= count_nxt;
      end
      if (s2_load) begin
        out_valid  <= s1_valid_r;
        s1_valid_r <= in_acc;
      end else if (in_acc) begin
        s1_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r <= s1_nxt;
    end
    if (s2_load && s1_valid_r) begin
      out_r <= result;
    end
  end

  assign out_data = out_r;

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid && out_stall))
    else $error("input stalled while the pipeline has room");

  a_restart_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.restart && nlen_r != '0) |=> (phase_r == $past(step_ext)))
    else $error("phase after a restart beat is not one step");

  a_quiet_no_clip: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.note_active) |-> !out_data.clipped)
    else $error("clip reported on a beat without tone");

  a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_valid) |=> out_valid)
    else $error("first stage beat did not advance into an empty output stage");

endmodule

/* sv/tom_shape.sv */
`timescale 1ns / 1ps
// Waveform generator: turns the phase and instrument into a Q15 shape value.
// Depends on tom_pkg for sizes, the shape decode and the quarter sine table.
module tom_shape (
  input  logic [tom_pkg::PHASE_BITS-1:0]    phase,
  input  logic [tom_pkg::INST_W-1:0]        instrument,
  output logic signed [tom_pkg::WAVE_W-1:0] wave
);
  import tom_pkg::*;

  logic [15:0]              u;
  logic [SIN_AW-1:0]        sidx;
  logic [QAW-1:0]           r;
  logic [QAW:0]             fold;
  logic [QAW-1:0]           qi;
  logic [MAG_W-1:0]         qv;
  logic signed [WAVE_W-1:0] sine_w;
  logic signed [WAVE_W-1:0] sq_w;
  logic signed [WAVE_W-1:0] saw_w;
  logic signed [18:0]       u2;
  logic signed [18:0]       tri19;

  assign u    = phase[PHASE_BITS-1 -: 16];
  assign sidx = phase[PHASE_BITS-1 -: SIN_AW];
  assign r    = sidx[SIN_AW-2:0];
  assign fold = (QAW+1)'(SINE_DEPTH / 2) - {1'b0, r};
  assign qi   = (r > QAW'(QTR)) ? fold[QAW-1:0] : r;
  assign qv   = SIN_QTAB[qi];

  assign sine_w = sidx[SIN_AW-1] ? -$signed({1'b0, qv}) : $signed({1'b0, qv});
  assign sq_w   = u[15] ? -WAVE_FULL : WAVE_FULL;
  assign saw_w  = $signed({1'b0, u}) - WAVE_FULL;

  assign u2 = $signed({2'b00, u, 1'b0});

  always_comb begin
    if (u < 16'd16384) begin
      tri19 = u2;
    end else if (u < 16'd49152) begin
      tri19 = 19'sd65536 - u2;
    end else begin
      tri19 = u2 - 19'sd131072;
    end
  end

  always_comb begin
    case (shape_of(instrument))
      SHAPE_SQUARE: wave = sq_w;
      SHAPE_SAW:    wave = saw_w;
      SHAPE_TRI:    wave = tri19[WAVE_W-1:0];
      default:      wave = sine_w;
    endcase
  end

endmodule

/* sv/tom_scale.sv */
`timescale 1ns / 1ps
// Gain scaling and saturating mix: scales the shape value, clips the tone and
// adds it to the mix sample. Depends on tom_pkg for sizes and beat types.
module tom_scale (
  input  tom_pkg::tone_stage_t       stage,
  input  logic [tom_pkg::GAIN_W-1:0] gain,
  output tom_pkg::out_beat_t         result
);
  import tom_pkg::*;

  logic                         neg;
  logic [WAVE_W-1:0]            magw;
  logic [MAG_W-1:0]             mag;
  logic [SCL_W-1:0]             scaled;
  logic [PROD_W-1:0]            prod;
  logic [TMAG_W-1:0]            tmag;
  logic signed [SAMPLE_W-1:0]   tone;
  logic                         tone_clip;
  logic signed [SAMPLE_W:0]     sum;
  logic signed [SAMPLE_W-1:0]   mixed;
  logic                         sum_clip;

  assign neg    = stage.wave[WAVE_W-1];
  assign magw   = neg ? WAVE_W'(-stage.wave) : WAVE_W'(stage.wave);
  assign mag    = magw[MAG_W-1:0];
  // Multiplying by 32767 is a shift and a subtract.
  assign scaled = {mag, 15'd0} - {15'd0, mag};
  assign prod   = PROD_W'(scaled) * PROD_W'(gain);
  assign tmag   = prod[PROD_W-1:29];

  always_comb begin
    tone_clip = 1'b0;
    if (!neg) begin
      if (tmag > TMAG_W'(32767)) begin
        tone      = SAMPLE_MAX;
        tone_clip = 1'b1;
      end else begin
        tone = $signed(tmag[SAMPLE_W-1:0]);
      end
    end else begin
      if (tmag > TMAG_W'(32768)) begin
        tone      = SAMPLE_MIN;
        tone_clip = 1'b1;
      end else begin
        tone = -$signed(tmag[SAMPLE_W-1:0]);
      end
    end
  end

  assign sum = {stage.mix[SAMPLE_W-1], stage.mix} + {tone[SAMPLE_W-1], tone};

  always_comb begin
    sum_clip = 1'b0;
    mixed    = sum[SAMPLE_W-1:0];
    if (sum[SAMPLE_W] != sum[SAMPLE_W-1]) begin
      sum_clip = 1'b1;
      mixed    = sum[SAMPLE_W] ? SAMPLE_MIN : SAMPLE_MAX;
    end
  end

  always_comb begin
    if (stage.active) begin
      result.sample_out  = mixed;
      result.clipped     = tone_clip | sum_clip;
      result.note_active = 1'b1;
    end else begin
      result.sample_out  = stage.mix;
      result.clipped     = 1'b0;
      result.note_active = 1'b0;
    end
  end

endmodule
